>>> rtl/indexed_array_store_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed array store
// Shared concurrent-assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_STORE_DEFINES_SVH
`define INDEXED_ARRAY_STORE_DEFINES_SVH

// Plain property, clocked on clk_i, off while rst_ni is low
`define IAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication
`define IAS_ASSERT_IMP(lbl, ante, cons, msg) \
  `IAS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define IAS_ASSERT_NXT(lbl, ante, cons, msg) \
  `IAS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/ias_pkg.sv
// ---------------------------------------------------------------------------
// ias_pkg
// Types and constants shared by the indexed array store.
// ---------------------------------------------------------------------------
`default_nettype none

package ias_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_OVERWRITE = 3'd1,
    MODE_DELETE    = 3'd2,
    MODE_READ      = 3'd3,
    MODE_FIRST     = 3'd4,
    MODE_LAST      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/ias_mem.sv
// ---------------------------------------------------------------------------
// ias_mem
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ias_mem #(
  parameter  int unsigned DEPTH = ias_pkg::CAPACITY_DEF,
  parameter  int unsigned WIDTH = ias_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/indexed_array_store.sv
// ---------------------------------------------------------------------------
// indexed_array_store
// Packed array of up to CAPACITY words with a live element count.
// ---------------------------------------------------------------------------
// Each transfer on the input carries one request (append, overwrite, delete
// with shift-down, read at position, read first, read last) and produces
// exactly one response with status, data and the count after the request.
// Append, overwrite, the reads and refused requests sustain one request per
// cycle while the output is not stalled: the request is checked and its
// memory access issued in the cycle it is taken, and the response is loaded
// into the output register from the response state once the output is free,
// while the next request is taken. A delete at position p on a store of n
// entries holds off new requests while the n - p - 1 entries above p move
// down one per cycle through the single write port of the element RAM, and
// then closes the move in the shift state before its response is loaded.
// Element contents are undefined after reset; the bounds checks keep
// unwritten entries from ever being read, so there is no clearing pass and
// the block is ready right after reset.
`default_nettype none

`include "indexed_array_store_defines.svh"

module indexed_array_store #(
  parameter int unsigned CAPACITY   = ias_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ias_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ias_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ias_pkg::rsp_t out_data_o
);

  import ias_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;
  status_e         rsp_status_q, rsp_status_d;
  logic            rsp_use_q, rsp_use_d;
  logic            out_valid_q;
  rsp_t            out_data_q;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic            out_free;
  logic            accept;
  logic            push;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            in_range;
  logic            is_empty;
  logic            is_full;
  logic [SW-1:0]   shift_ext;

  ias_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Handshake
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_RESP:  in_stall_o = !out_free;
      ST_SHIFT: in_stall_o = 1'b1;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;
  assign push   = (state_q == ST_RESP) && out_free;

  // Bounds checks against the live count
  assign pos_ext   = CMPW'(in_data_i.position);
  assign cnt_ext   = CMPW'(count_q);
  assign in_range  = pos_ext < cnt_ext;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign shift_ext = SW'(idx_q);

  // Request decode, shift sequencer and RAM control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    rsp_status_d = rsp_status_q;
    rsp_use_d    = rsp_use_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    // Move one entry down per cycle: write idx with the word read from idx+1
    if (state_q == ST_SHIFT) begin
      if (shift_ext < SW'(count_q)) begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mem_rdata;
        idx_d     = idx_q + AW'(1);
        if (shift_ext + SW'(1) < SW'(count_q)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(shift_ext + SW'(2));
        end
      end else begin
        state_d = ST_RESP;
      end
    end

    if (push) begin
      state_d = ST_IDLE;
    end

    if (accept) begin
      state_d      = ST_RESP;
      rsp_status_d = STS_OK;
      rsp_use_d    = 1'b0;
      unique case (in_data_i.mode)
        MODE_APPEND: begin
          if (is_full) begin
            rsp_status_d = STS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_q);
            mem_wdata = DATA_WIDTH'(in_data_i.value);
            count_d   = count_q + CW'(1);
          end
        end
        MODE_OVERWRITE: begin
          if (!in_range) begin
            rsp_status_d = STS_RANGE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(in_data_i.position);
            mem_wdata = DATA_WIDTH'(in_data_i.value);
          end
        end
        MODE_DELETE: begin
          if (!in_range) begin
            rsp_status_d = STS_RANGE;
          end else begin
            count_d = count_q - CW'(1);
            idx_d   = AW'(in_data_i.position);
            state_d = ST_SHIFT;
            // prefetch the first word to move down
            if (pos_ext + CMPW'(1) < cnt_ext) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_ext + CMPW'(1));
            end
          end
        end
        MODE_READ: begin
          if (!in_range) begin
            rsp_status_d = STS_RANGE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_data_i.position);
            rsp_use_d = 1'b1;
          end
        end
        MODE_FIRST: begin
          if (is_empty) begin
            rsp_status_d = STS_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            rsp_use_d = 1'b1;
          end
        end
        MODE_LAST: begin
          if (is_empty) begin
            rsp_status_d = STS_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_q - CW'(1));
            rsp_use_d = 1'b1;
          end
        end
        default: begin
          // unused modes: no change, plain ok response
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Per-request bookkeeping
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    rsp_status_q <= rsp_status_d;
    rsp_use_q    <= rsp_use_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q.status <= rsp_status_q;
      out_data_q.data   <= rsp_use_q ? DATA_W'(mem_rdata) : '0;
      out_data_q.count  <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `IAS_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "live count above capacity")
  `IAS_ASSERT_NXT(a_count_held_in_shift, state_q == ST_SHIFT, $stable(count_q),
                  "count changed during shift")
  `IAS_ASSERT_IMP(a_shift_write_live, (state_q == ST_SHIFT) && mem_we,
                  SW'(mem_waddr) < SW'(count_q), "shift wrote past live entries")
  `IAS_ASSERT_IMP(a_no_port_collision, mem_we && mem_re, mem_waddr != mem_raddr,
                  "read and write hit the same entry")
  `IAS_ASSERT_IMP(a_resp_from_resp_state, $rose(out_valid_q), $past(state_q == ST_RESP),
                  "response loaded outside response state")

endmodule

`default_nettype wire
